// File: rtl/core/bmcs_pkg.sv
// Shared constants, command codes and types of the Bezier middle control point solver.
package bmcs_pkg;

   localparam int HALVINGS   = 14;
   localparam int ROUND_W    = $clog2(HALVINGS);
   localparam int T_W        = 17;
   localparam logic [T_W-1:0] ONE_T = 17'h10000;
   localparam int COORD_W    = 32;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int WIDE_W     = 128;
   localparam int CHUNK_W    = 32;
   localparam int MUL_W      = 34;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int NUM_W      = 68;
   localparam int DVSR_W     = 33;
   localparam int DIV_STEPS  = NUM_W;
   localparam int DSTEP_W    = $clog2(DIV_STEPS);
   localparam int REQ_DATA_W = 6 * COORD_W;
   localparam int RSP_DATA_W = 88;

   // datapath operations
   localparam logic [3:0] OP_NOP    = 4'd0;
   localparam logic [3:0] OP_LOAD   = 4'd1;
   localparam logic [3:0] OP_MUL    = 4'd2;
   localparam logic [3:0] OP_ACC    = 4'd3;
   localparam logic [3:0] OP_COEF   = 4'd4;
   localparam logic [3:0] OP_HLOAD  = 4'd5;
   localparam logic [3:0] OP_MAC    = 4'd6;
   localparam logic [3:0] OP_DECIDE = 4'd7;
   localparam logic [3:0] OP_FINAL  = 4'd8;
   localparam logic [3:0] OP_MINIT  = 4'd9;
   localparam logic [3:0] OP_DPREP  = 4'd10;
   localparam logic [3:0] OP_DIV    = 4'd11;
   localparam logic [3:0] OP_EMIT   = 4'd12;

   // multiplier operand selects, in issue order
   localparam logic [3:0] SEL_UXUX = 4'd0;
   localparam logic [3:0] SEL_UYUY = 4'd1;
   localparam logic [3:0] SEL_UXVX = 4'd2;
   localparam logic [3:0] SEL_UYVY = 4'd3;
   localparam logic [3:0] SEL_VXVX = 4'd4;
   localparam logic [3:0] SEL_VYVY = 4'd5;
   localparam logic [3:0] SEL_SS   = 4'd6;
   localparam logic [3:0] SEL_KK   = 4'd7;
   localparam logic [3:0] SEL_KS   = 4'd8;
   localparam logic [3:0] SEL_SXSS = 4'd9;
   localparam logic [3:0] SEL_EXKK = 4'd10;
   localparam logic [3:0] SEL_SYSS = 4'd11;
   localparam logic [3:0] SEL_EYKK = 4'd12;

   localparam logic [1:0] LAST_CHUNK  = 2'd3;
   localparam logic [1:0] LAST_HSTAGE = 2'd2;

   typedef struct packed {
      logic [3:0] op;
      logic [3:0] sel;
      logic [1:0] chunk;
      logic [1:0] hstage;
   } bmcs_cmd_type;

   typedef struct packed {
      logic zero_hit;
   } bmcs_stat_type;

   typedef struct packed {
      logic               saturated;
      logic               exact_root;
      logic [COORD_W-1:0] middle_y;
      logic [COORD_W-1:0] middle_x;
      logic [T_W-1:0]     param_t;
   } bmcs_result_type;

endpackage

// File: rtl/core/bmcs_datapath.sv
// Datapath: shared multiplier, cubic evaluation by chunked Horner steps, divider.
module bmcs_datapath (
   input  logic                          clock,
   input  bmcs_pkg::bmcs_cmd_type        cmd,
   input  logic [bmcs_pkg::REQ_DATA_W-1:0] req_data,
   output bmcs_pkg::bmcs_stat_type       stat,
   output bmcs_pkg::bmcs_result_type     result
);
   import bmcs_pkg::*;

   logic signed [COORD_W-1:0] sx_ff, sy_ff, ex_ff, ey_ff, qx_ff, qy_ff;
   logic signed [DIFF_W-1:0]  ux_ff, uy_ff, vx_ff, vy_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [WIDE_W-1:0] uu_ff, uv_ff, vv_ff, ca_ff, cb_ff, cc_ff, cd_ff;
   logic [WIDE_W-1:0] cur_ff, acc_ff, f0_ff;
   logic [T_W-1:0]    k_ff, t0_ff, t1_ff, t_ff;
   logic              exact_ff;
   logic [32:0]       ss_ff, kk_ff;
   logic [31:0]       ks_ff;
   logic [NUM_W-1:0]  nx_ff, ny_ff, dvx_ff, dvy_ff, qox_ff, qoy_ff;
   logic [DVSR_W:0]   rmx_ff, rmy_ff;
   logic [DVSR_W-1:0] dvsr_ff;
   logic              negx_ff, negy_ff;

   logic signed [MUL_W-1:0] ma, mb;
   logic [WIDE_W-1:0]  prod_wide, part_wide, neg_vv;
   logic [CHUNK_W-1:0] chunk_val;
   logic [CHUNK_W+T_W-1:0] chunk_prod;
   logic [T_W:0]       tsum;
   logic [T_W-1:0]     s_val;
   logic [31:0]        d_val;
   logic [NUM_W-1:0]   magx, magy;
   logic [DVSR_W:0]    rx2, ry2;
   logic               gex, gey;

   assign s_val     = ONE_T - t_ff;
   assign tsum      = {1'b0, t0_ff} + {1'b0, t1_ff};
   assign prod_wide = {{(WIDE_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign neg_vv    = -vv_ff;
   assign chunk_val = cur_ff[cmd.chunk*CHUNK_W +: CHUNK_W];
   assign chunk_prod = chunk_val * k_ff;
   assign part_wide = {{(WIDE_W-CHUNK_W-T_W){1'b0}}, chunk_prod} << (CHUNK_W * cmd.chunk);
   assign d_val     = (ks_ff == '0) ? 32'd1 : {ks_ff[30:0], 1'b0};
   assign magx      = nx_ff[NUM_W-1] ? -nx_ff : nx_ff;
   assign magy      = ny_ff[NUM_W-1] ? -ny_ff : ny_ff;
   assign rx2       = {rmx_ff[DVSR_W-1:0], dvx_ff[NUM_W-1]};
   assign ry2       = {rmy_ff[DVSR_W-1:0], dvy_ff[NUM_W-1]};
   assign gex       = rx2 >= {1'b0, dvsr_ff};
   assign gey       = ry2 >= {1'b0, dvsr_ff};

   assign stat.zero_hit = (acc_ff == '0) || (f0_ff == '0);

   always_comb begin
      ma = '0;
      mb = '0;
      unique case (cmd.sel)
         SEL_UXUX: begin ma = MUL_W'(ux_ff); mb = MUL_W'(ux_ff); end
         SEL_UYUY: begin ma = MUL_W'(uy_ff); mb = MUL_W'(uy_ff); end
         SEL_UXVX: begin ma = MUL_W'(ux_ff); mb = MUL_W'(vx_ff); end
         SEL_UYVY: begin ma = MUL_W'(uy_ff); mb = MUL_W'(vy_ff); end
         SEL_VXVX: begin ma = MUL_W'(vx_ff); mb = MUL_W'(vx_ff); end
         SEL_VYVY: begin ma = MUL_W'(vy_ff); mb = MUL_W'(vy_ff); end
         SEL_SS:   begin ma = {17'd0, s_val}; mb = {17'd0, s_val}; end
         SEL_KK:   begin ma = {17'd0, t_ff}; mb = {17'd0, t_ff}; end
         SEL_KS:   begin ma = {17'd0, t_ff}; mb = {17'd0, s_val}; end
         SEL_SXSS: begin ma = MUL_W'(sx_ff); mb = {1'b0, ss_ff}; end
         SEL_EXKK: begin ma = MUL_W'(ex_ff); mb = {1'b0, kk_ff}; end
         SEL_SYSS: begin ma = MUL_W'(sy_ff); mb = {1'b0, ss_ff}; end
         SEL_EYKK: begin ma = MUL_W'(ey_ff); mb = {1'b0, kk_ff}; end
         default:  begin ma = '0; mb = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            sx_ff <= req_data[0*COORD_W +: COORD_W];
            sy_ff <= req_data[1*COORD_W +: COORD_W];
            ex_ff <= req_data[2*COORD_W +: COORD_W];
            ey_ff <= req_data[3*COORD_W +: COORD_W];
            qx_ff <= req_data[4*COORD_W +: COORD_W];
            qy_ff <= req_data[5*COORD_W +: COORD_W];
            ux_ff <= DIFF_W'($signed(req_data[2*COORD_W +: COORD_W]))
                   - DIFF_W'($signed(req_data[0*COORD_W +: COORD_W]));
            uy_ff <= DIFF_W'($signed(req_data[3*COORD_W +: COORD_W]))
                   - DIFF_W'($signed(req_data[1*COORD_W +: COORD_W]));
            vx_ff <= DIFF_W'($signed(req_data[0*COORD_W +: COORD_W]))
                   - DIFF_W'($signed(req_data[4*COORD_W +: COORD_W]));
            vy_ff <= DIFF_W'($signed(req_data[1*COORD_W +: COORD_W]))
                   - DIFF_W'($signed(req_data[5*COORD_W +: COORD_W]));
            uu_ff <= '0;
            uv_ff <= '0;
            vv_ff <= '0;
            exact_ff <= 1'b0;
         end
         OP_MUL: prod_ff <= ma * mb;
         OP_ACC: begin
            case (cmd.sel)
               SEL_UXUX, SEL_UYUY: uu_ff <= uu_ff + prod_wide;
               SEL_UXVX, SEL_UYVY: uv_ff <= uv_ff + prod_wide;
               SEL_VXVX, SEL_VYVY: vv_ff <= vv_ff + prod_wide;
               SEL_SS:             ss_ff <= prod_ff[32:0];
               SEL_KK:             kk_ff <= prod_ff[32:0];
               SEL_KS:             ks_ff <= prod_ff[31:0];
               SEL_SXSS, SEL_EXKK: nx_ff <= nx_ff - NUM_W'(prod_ff);
               SEL_SYSS, SEL_EYKK: ny_ff <= ny_ff - NUM_W'(prod_ff);
               default: ;
            endcase
         end
         OP_COEF: begin
            ca_ff <= uu_ff;
            cb_ff <= uv_ff + (uv_ff << 1);
            cc_ff <= (vv_ff << 1) - uv_ff;
            cd_ff <= neg_vv;
            f0_ff <= neg_vv << 48;
            t0_ff <= '0;
            t1_ff <= ONE_T;
         end
         OP_HLOAD: begin
            case (cmd.hstage)
               2'd0: begin
                  k_ff   <= tsum[T_W:1];
                  cur_ff <= ca_ff;
                  acc_ff <= cb_ff << 16;
               end
               2'd1: begin
                  cur_ff <= acc_ff;
                  acc_ff <= cc_ff << 32;
               end
               default: begin
                  cur_ff <= acc_ff;
                  acc_ff <= cd_ff << 48;
               end
            endcase
         end
         OP_MAC: acc_ff <= acc_ff + part_wide;
         OP_DECIDE: begin
            if (acc_ff == '0) begin
               t_ff     <= k_ff;
               exact_ff <= 1'b1;
            end else if (f0_ff == '0) begin
               t_ff     <= t0_ff;
               exact_ff <= 1'b1;
            end else if (acc_ff[WIDE_W-1] != f0_ff[WIDE_W-1]) begin
               t1_ff <= k_ff;
            end else begin
               t0_ff <= k_ff;
               f0_ff <= acc_ff;
            end
         end
         OP_FINAL: t_ff <= tsum[T_W:1];
         OP_MINIT: begin
            nx_ff <= {{(NUM_W-64){qx_ff[COORD_W-1]}}, qx_ff, 32'd0};
            ny_ff <= {{(NUM_W-64){qy_ff[COORD_W-1]}}, qy_ff, 32'd0};
         end
         OP_DPREP: begin
            negx_ff <= nx_ff[NUM_W-1];
            negy_ff <= ny_ff[NUM_W-1];
            dvx_ff  <= {magx[NUM_W-2:0], 1'b0} + NUM_W'(d_val);
            dvy_ff  <= {magy[NUM_W-2:0], 1'b0} + NUM_W'(d_val);
            dvsr_ff <= {d_val, 1'b0};
            rmx_ff  <= '0;
            rmy_ff  <= '0;
            qox_ff  <= '0;
            qoy_ff  <= '0;
         end
         OP_DIV: begin
            dvx_ff <= {dvx_ff[NUM_W-2:0], 1'b0};
            dvy_ff <= {dvy_ff[NUM_W-2:0], 1'b0};
            rmx_ff <= gex ? rx2 - {1'b0, dvsr_ff} : rx2;
            rmy_ff <= gey ? ry2 - {1'b0, dvsr_ff} : ry2;
            qox_ff <= {qox_ff[NUM_W-2:0], gex};
            qoy_ff <= {qoy_ff[NUM_W-2:0], gey};
         end
         default: ;
      endcase
   end

   // saturate and restore sign
   logic satx, saty;
   always_comb begin
      satx = negx_ff ? ((|qox_ff[NUM_W-1:32]) || (qox_ff[31] && (|qox_ff[30:0])))
                     : (|qox_ff[NUM_W-1:31]);
      saty = negy_ff ? ((|qoy_ff[NUM_W-1:32]) || (qoy_ff[31] && (|qoy_ff[30:0])))
                     : (|qoy_ff[NUM_W-1:31]);
      result.param_t    = t_ff;
      result.exact_root = exact_ff;
      result.saturated  = satx || saty;
      if (satx)
         result.middle_x = negx_ff ? 32'h8000_0000 : 32'h7fff_ffff;
      else
         result.middle_x = negx_ff ? -qox_ff[31:0] : qox_ff[31:0];
      if (saty)
         result.middle_y = negy_ff ? 32'h8000_0000 : 32'h7fff_ffff;
      else
         result.middle_y = negy_ff ? -qoy_ff[31:0] : qoy_ff[31:0];
   end

endmodule

// File: rtl/core/bmcs_ctrl.sv
// Controller state machine sequencing products, bisection rounds and division.
module bmcs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    slot_free,
   input  bmcs_pkg::bmcs_stat_type stat,
   output bmcs_pkg::bmcs_cmd_type  cmd
);
   import bmcs_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MUL    = 4'd1;
   localparam logic [3:0] S_ACC    = 4'd2;
   localparam logic [3:0] S_COEF   = 4'd3;
   localparam logic [3:0] S_HLOAD  = 4'd4;
   localparam logic [3:0] S_MAC    = 4'd5;
   localparam logic [3:0] S_DECIDE = 4'd6;
   localparam logic [3:0] S_FINAL  = 4'd7;
   localparam logic [3:0] S_MINIT  = 4'd8;
   localparam logic [3:0] S_DPREP  = 4'd9;
   localparam logic [3:0] S_DIV    = 4'd10;
   localparam logic [3:0] S_EMIT   = 4'd11;

   logic [3:0]         state_ff, state_in;
   logic [3:0]         sel_ff, sel_in;
   logic [1:0]         chunk_ff, chunk_in, hstage_ff, hstage_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [DSTEP_W-1:0] dcnt_ff, dcnt_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      sel_in     = sel_ff;
      chunk_in   = chunk_ff;
      hstage_in  = hstage_ff;
      round_in   = round_ff;
      dcnt_in    = dcnt_ff;
      cmd.op     = OP_NOP;
      cmd.sel    = sel_ff;
      cmd.chunk  = chunk_ff;
      cmd.hstage = hstage_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               sel_in   = SEL_UXUX;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.op   = OP_MUL;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = OP_ACC;
            if (sel_ff == SEL_VYVY) begin
               state_in = S_COEF;
            end else if (sel_ff == SEL_EYKK) begin
               state_in = S_DPREP;
            end else begin
               sel_in   = sel_ff + 4'd1;
               state_in = S_MUL;
            end
         end
         S_COEF: begin
            cmd.op    = OP_COEF;
            round_in  = '0;
            hstage_in = '0;
            state_in  = S_HLOAD;
         end
         S_HLOAD: begin
            cmd.op   = OP_HLOAD;
            chunk_in = '0;
            state_in = S_MAC;
         end
         S_MAC: begin
            cmd.op = OP_MAC;
            if (chunk_ff == LAST_CHUNK) begin
               if (hstage_ff == LAST_HSTAGE) begin
                  state_in = S_DECIDE;
               end else begin
                  hstage_in = hstage_ff + 2'd1;
                  state_in  = S_HLOAD;
               end
            end else begin
               chunk_in = chunk_ff + 2'd1;
            end
         end
         S_DECIDE: begin
            cmd.op = OP_DECIDE;
            if (stat.zero_hit) begin
               state_in = S_MINIT;
            end else if (round_ff == ROUND_W'(HALVINGS - 1)) begin
               state_in = S_FINAL;
            end else begin
               round_in  = round_ff + 1'b1;
               hstage_in = '0;
               state_in  = S_HLOAD;
            end
         end
         S_FINAL: begin
            cmd.op   = OP_FINAL;
            state_in = S_MINIT;
         end
         S_MINIT: begin
            cmd.op   = OP_MINIT;
            sel_in   = SEL_SS;
            state_in = S_MUL;
         end
         S_DPREP: begin
            cmd.op   = OP_DPREP;
            dcnt_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            if (dcnt_ff == DSTEP_W'(DIV_STEPS - 1))
               state_in = S_EMIT;
            else
               dcnt_in = dcnt_ff + 1'b1;
         end
         S_EMIT: begin
            if (slot_free) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         sel_ff    <= '0;
         chunk_ff  <= '0;
         hstage_ff <= '0;
         round_ff  <= '0;
         dcnt_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         sel_ff    <= sel_in;
         chunk_ff  <= chunk_in;
         hstage_ff <= hstage_in;
         round_ff  <= round_in;
         dcnt_ff   <= dcnt_in;
      end
   end

`ifndef SYNTH
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      round_ff <= ROUND_W'(HALVINGS - 1)) else $error("round count out of range");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_MUL && sel_ff == SEL_UXUX))
      else $error("accepted item did not start product sequence");
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |-> slot_free) else $error("result emitted into full slot");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (dcnt_ff <= DSTEP_W'(DIV_STEPS - 1)))
      else $error("divider overran its step count");
`endif

endmodule

// File: rtl/core/bezier_middle_control_solver.sv
// Top level of the quadratic Bezier middle control point solver.
// Usage:
//  - req channel: one transfer carries P0, P2 and the target point Q (Q16.16).
//  - rsp channel: one transfer per request with the root t (Q1.16), the middle
//    control point (Q16.16, saturated), the exact-root and saturation flags.
//  - Bisection takes one to 14 rounds of chunked Horner evaluation, plus a final
//    midpoint step when it runs all rounds, and then the 68-step restoring
//    divider runs; one item is in work at a time.
//  - A finished result waits in the output register; the next request is
//    accepted while it waits, so a stalled receiver only holds the block once
//    a second result is ready to be written.
//  - Reset (synchronous, active high) returns the controller to idle and
//    empties the output register.
module bezier_middle_control_solver (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // start_x, start_y, end_x, end_y, target_x, target_y (32 bits each)
   input  logic [bmcs_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // param_t[16:0], middle_x[48:17], middle_y[80:49], exact_root[81],
   // saturated[82], zero fill[87:83]
   output logic [bmcs_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bmcs_pkg::*;

   bmcs_cmd_type    cmd;
   bmcs_stat_type   stat;
   bmcs_result_type result;
   logic            rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic            slot_free;

   // the slot frees when empty or drained in this cycle
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   bmcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .slot_free  (slot_free),
      .stat       (stat),
      .cmd        (cmd)
   );

   bmcs_datapath u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_tdata),
      .stat     (stat),
      .result   (result)
   );

   // hold the result until the receiver takes the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         rsp_data_ff <= {{(RSP_DATA_W - $bits(result)){1'b0}}, result};
      end
   end

endmodule

// File: tb/tb.sv
// Self-checking testbench of the Bezier middle control point solver.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bmcs_pkg::*;

   localparam int N_RANDOM   = 400;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYC  = 400;

   typedef struct packed {
      logic [31:0] target_y;
      logic [31:0] target_x;
      logic [31:0] end_y;
      logic [31:0] end_x;
      logic [31:0] start_y;
      logic [31:0] start_x;
   } segment_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   segment_type     segment_q[$];
   bmcs_result_type middle_q[$];
   int              errors;
   int              idle_cycles;
   int              send_gap;
   int              recv_gap;
   bit              hold_off;
   bit              stim_done;

   bezier_middle_control_solver i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Cubic in Q1.16 grid point k, scaled by 2^48, Horner form, 128-bit wrap.
   function automatic logic signed [127:0] cubic_at(logic signed [127:0] ca,
         logic signed [127:0] cb, logic signed [127:0] cc, logic signed [127:0] cd,
         logic [16:0] k);
      logic signed [127:0] r;
      logic signed [127:0] kk;
      kk = $signed({111'd0, k});
      r = ca * kk;
      r = (r + (cb <<< 16)) * kk;
      r = (r + (cc <<< 32)) * kk;
      return r + (cd <<< 48);
   endfunction

   // One middle coordinate: round half away from zero, clip to 32 bits.
   function automatic logic [31:0] middle_coord(logic signed [31:0] p0,
         logic signed [31:0] p2, logic signed [31:0] q, logic [16:0] k,
         logic [16:0] s, logic [33:0] d, ref bit sat);
      logic signed [127:0] num;
      logic [127:0]        mag;
      logic                neg;
      num = ($signed({{96{q[31]}}, q}) <<< 32)
          - $signed({{96{p0[31]}}, p0}) * $signed({94'd0, (34'(s) * 34'(s))})
          - $signed({{96{p2[31]}}, p2}) * $signed({94'd0, (34'(k) * 34'(k))});
      neg = num[127];
      mag = neg ? -num : num;
      mag = ((mag << 1) + {94'd0, d}) / ({94'd0, d} << 1);
      if (neg) begin
         if (mag > 128'h80000000) begin
            sat = 1'b1;
            return 32'h80000000;
         end
         return 32'(-mag);
      end
      if (mag > 128'h7fffffff) begin
         sat = 1'b1;
         return 32'h7fffffff;
      end
      return mag[31:0];
   endfunction

   function automatic bmcs_result_type solve_middle(segment_type seg);
      logic signed [127:0] ux, uy, vx, vy, uu, uv, vv, ca, cb, cc, cd, fm, f0;
      logic [16:0]         t0, t1, m, t, s;
      logic [33:0]         d;
      bit                  exact, sat;
      bmcs_result_type     r;
      ux = $signed(seg.end_x) - $signed(seg.start_x);
      uy = $signed(seg.end_y) - $signed(seg.start_y);
      vx = $signed(seg.start_x) - $signed(seg.target_x);
      vy = $signed(seg.start_y) - $signed(seg.target_y);
      uu = ux * ux + uy * uy;
      uv = ux * vx + uy * vy;
      vv = vx * vx + vy * vy;
      ca = uu;
      cb = uv * 3;
      cc = vv * 2 - uv;
      cd = -vv;
      t0 = 17'd0;
      t1 = ONE_T;
      t = 17'd0;
      exact = 1'b0;
      sat = 1'b0;
      for (int i = 0; i < HALVINGS; i++) begin
         m = 17'((18'(t0) + 18'(t1)) >> 1);
         fm = cubic_at(ca, cb, cc, cd, m);
         f0 = cubic_at(ca, cb, cc, cd, t0);
         if (fm == 0) begin
            t = m;
            exact = 1'b1;
            break;
         end
         if (f0 == 0) begin
            t = t0;
            exact = 1'b1;
            break;
         end
         if (fm[127] != f0[127]) t1 = m;
         else t0 = m;
      end
      if (!exact) t = 17'((18'(t0) + 18'(t1)) >> 1);
      s = ONE_T - t;
      d = 34'(2 * 34'(t) * 34'(s));
      if (d == 0) d = 34'd1;   // floor the degenerate divisor at one step
      r.param_t    = t;
      r.middle_x   = middle_coord(seg.start_x, seg.end_x, seg.target_x, t, s, d, sat);
      r.middle_y   = middle_coord(seg.start_y, seg.end_y, seg.target_y, t, s, d, sat);
      r.exact_root = exact;
      r.saturated  = sat;
      return r;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      endcase
   endfunction

   // Fill the pending queue: directed extremes first, then random segments.
   initial begin
      segment_type seg;
      int          k;
      seg = '0;
      segment_q = {segment_q, seg};                   // coincident points
      seg = '{default: 32'h7fffffff};
      segment_q = {segment_q, seg};
      seg = '{default: 32'h80000000};
      segment_q = {segment_q, seg};
      seg = '{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
              32'h80000000, 32'h7fffffff};            // overflowing middle point
      segment_q = {segment_q, seg};
      seg = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0};
      segment_q = {segment_q, seg};
      seg = '{0, 0, 32'h00010000, 32'h00010000, 0, 0}; // target on an endpoint
      segment_q = {segment_q, seg};
      seg = '{32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000, 0, 0};
      segment_q = {segment_q, seg};
      seg = '{32'h00008000, 32'h00008000, 32'h00010000, 32'h00010000, 0, 0};
      segment_q = {segment_q, seg};                   // exact midpoint root
      seg = '{32'h00004000, 32'h00020000, 0, 32'h00040000, 0, 0};
      segment_q = {segment_q, seg};
      seg = '{32'h00ff0000, 32'hff000000, 32'h12345678, 32'h87654321,
              32'h55555555, 32'haaaaaaaa};
      segment_q = {segment_q, seg};
      for (k = 0; k < 10; k++) begin
         seg = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         segment_q = {segment_q, seg};
      end
      for (k = 0; k < N_RANDOM; k++) begin
         seg = '{pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                 pick_coord(), pick_coord()};
         if ($urandom_range(0, 9) == 0) seg.target_x = seg.start_x;
         if ($urandom_range(0, 9) == 0) seg.target_y = seg.end_y;
         segment_q = {segment_q, seg};
      end
   end

   // Driver: one transfer per pending segment, random gaps, one drain pause.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   <= 0;
         hold_off   <= 1'b0;
         stim_done  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            middle_q = {middle_q, solve_middle(segment_type'(req_tdata))};
            if (segment_q.size() == 230) hold_off <= 1'b1;
         end
         if (!req_tvalid || req_tready) begin
            if (hold_off && (middle_q.size() != 0 || (req_tvalid && req_tready))) begin
               req_tvalid <= 1'b0;   // hold until every result is back
            end else if (send_gap > 0) begin
               req_tvalid <= 1'b0;
               send_gap   <= send_gap - 1;
            end else if (segment_q.size() != 0) begin
               hold_off   <= 1'b0;
               req_tvalid <= 1'b1;
               req_tdata  <= segment_q.pop_front();
               send_gap   <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
               stim_done  <= 1'b1;
            end
         end
      end
   end

   // Monitor: random back pressure, compare each result transfer.
   always @(posedge clock) begin
      bmcs_result_type got;
      bmcs_result_type want;
      if (reset) begin
         rsp_tready  <= 1'b0;
         recv_gap    <= 0;
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = bmcs_result_type'(rsp_tdata[82:0]);
            if (middle_q.size() == 0) begin
               $error("unexpected result transfer %h", rsp_tdata);
               errors++;
            end else begin
               want = middle_q.pop_front();
               if (got.param_t != want.param_t) begin
                  $error("param_t expected %h got %h", want.param_t, got.param_t);
                  errors++;
               end
               if (got.middle_x != want.middle_x) begin
                  $error("middle_x expected %h got %h", want.middle_x, got.middle_x);
                  errors++;
               end
               if (got.middle_y != want.middle_y) begin
                  $error("middle_y expected %h got %h", want.middle_y, got.middle_y);
                  errors++;
               end
               if (got.exact_root != want.exact_root) begin
                  $error("exact_root expected %b got %b", want.exact_root,
                         got.exact_root);
                  errors++;
               end
               if (got.saturated != want.saturated) begin
                  $error("saturated expected %b got %b", want.saturated,
                         got.saturated);
                  errors++;
               end
            end
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (recv_gap > 0) begin
            rsp_tready <= 1'b0;
            recv_gap   <= recv_gap - 1;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap   <= pick_gap();
         end
      end
   end

   initial begin
      errors = 0;
      reset  = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            wait (stim_done && middle_q.size() == 0);
            repeat (DRAIN_CYC) @(posedge clock);
         end
         begin
            wait (idle_cycles >= IDLE_LIMIT);
            errors++;
            $error("watchdog expired");
         end
      join_any
      if (errors == 0 && middle_q.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
